FILE: rtl/i2jdec_pkg.sv
// Package for the ISO-2022-JP escape decoder: byte constants, set codes,
// escape phase encoding and the state and result structs.
// No dependencies.
package i2jdec_pkg;

	localparam logic [7:0] ESC_BYTE    = 8'h1B;
	localparam logic [7:0] CR_BYTE     = 8'h0D;
	localparam logic [7:0] DOLLAR_BYTE = 8'h24;
	localparam logic [7:0] AMP_BYTE    = 8'h26;
	localparam logic [7:0] LPAREN_BYTE = 8'h28;
	localparam logic [7:0] AT_BYTE     = 8'h40;
	localparam logic [7:0] B_BYTE      = 8'h42;
	localparam logic [7:0] J_BYTE      = 8'h4A;
	localparam logic [7:0] I_BYTE      = 8'h49;
	localparam logic [7:0] KANA_LOW    = 8'h20;
	localparam logic [7:0] KANA_HIGH   = 8'h60;
	localparam logic [7:0] KANA_OFFSET = 8'h80;

	typedef enum logic [2:0] {
		SET_ASCII = 3'd0,
		SET_ROMAN = 3'd1,
		SET_KANA  = 3'd2,
		SET_K1978 = 3'd3,
		SET_K1983 = 3'd4,
		SET_K1990 = 3'd5
	} char_set_t;

	typedef enum logic [7:0] {
		PH_START   = 8'b0000_0001,
		PH_ESC     = 8'b0000_0010,
		PH_DOLLAR  = 8'b0000_0100,
		PH_AMP     = 8'b0000_1000,
		PH_LPAREN  = 8'b0001_0000,
		PH_AMP_AT  = 8'b0010_0000,
		PH_ESC2    = 8'b0100_0000,
		PH_DOLLAR2 = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		phase_t    phase;
		char_set_t active_set;
		logic [7:0] lead_byte;
		logic       lead_pending;
	} dec_state_t;

	typedef struct packed {
		logic       valid;
		logic       status;
		char_set_t  char_set;
		logic [15:0] char_code;
	} dec_result_t;

endpackage

FILE: rtl/i2jdec_step.sv
// Combinational next-state and result logic for one stream byte.
// Depends on i2jdec_pkg.
module i2jdec_step
	import i2jdec_pkg::*;
(
	input  dec_state_t  cur,
	input  logic [7:0]  byte_in,
	input  logic        drop_cr,
	output dec_state_t  nxt,
	output dec_result_t res
);

	dec_result_t fail_res;
	logic        is_kanji;

	assign fail_res = '{valid: 1'b1, status: 1'b1, char_set: cur.active_set,
		char_code: 16'h0000};
	assign is_kanji = (cur.active_set == SET_K1978) || (cur.active_set == SET_K1983) ||
		(cur.active_set == SET_K1990);

	always_comb begin
		nxt = cur;
		res = '{valid: 1'b0, status: 1'b0, char_set: cur.active_set, char_code: 16'h0000};
		unique case (cur.phase)
			PH_START: begin
				if (byte_in == ESC_BYTE) begin
					nxt.lead_byte    = 8'h00;
					nxt.lead_pending = 1'b0;
					nxt.phase        = PH_ESC;
				end else if (is_kanji) begin
					if (!cur.lead_pending) begin
						nxt.lead_byte    = byte_in;
						nxt.lead_pending = 1'b1;
					end else begin
						nxt.lead_byte    = 8'h00;
						nxt.lead_pending = 1'b0;
						res.valid        = 1'b1;
						res.char_code    = {cur.lead_byte, byte_in};
					end
				end else if (cur.active_set == SET_KANA) begin
					if (byte_in > KANA_LOW && byte_in < KANA_HIGH) begin
						res.valid     = 1'b1;
						res.char_code = {8'h00, byte_in + KANA_OFFSET};
					end else begin
						res = fail_res;
					end
				end else begin
					// Ascii and roman pass the byte through, a CR optionally dropped.
					if (!(drop_cr && byte_in == CR_BYTE)) begin
						res.valid     = 1'b1;
						res.char_code = {8'h00, byte_in};
					end
				end
			end
			PH_ESC: begin
				if (byte_in == DOLLAR_BYTE) nxt.phase = PH_DOLLAR;
				else if (byte_in == AMP_BYTE) nxt.phase = PH_AMP;
				else if (byte_in == LPAREN_BYTE) nxt.phase = PH_LPAREN;
				else res = fail_res;
			end
			PH_DOLLAR: begin
				if (byte_in == AT_BYTE) begin
					nxt.active_set = SET_K1978;
					nxt.phase      = PH_START;
				end else if (byte_in == B_BYTE) begin
					nxt.active_set = SET_K1983;
					nxt.phase      = PH_START;
				end else begin
					res = fail_res;
				end
			end
			PH_AMP: begin
				if (byte_in == AT_BYTE) nxt.phase = PH_AMP_AT;
				else res = fail_res;
			end
			PH_LPAREN: begin
				if (byte_in == B_BYTE) begin
					nxt.active_set = SET_ASCII;
					nxt.phase      = PH_START;
				end else if (byte_in == J_BYTE) begin
					nxt.active_set = SET_ROMAN;
					nxt.phase      = PH_START;
				end else if (byte_in == I_BYTE) begin
					nxt.active_set = SET_KANA;
					nxt.phase      = PH_START;
				end else begin
					res = fail_res;
				end
			end
			PH_AMP_AT: begin
				if (byte_in == ESC_BYTE) nxt.phase = PH_ESC2;
				else res = fail_res;
			end
			PH_ESC2: begin
				if (byte_in == DOLLAR_BYTE) nxt.phase = PH_DOLLAR2;
				else res = fail_res;
			end
			PH_DOLLAR2: begin
				if (byte_in == B_BYTE) begin
					nxt.active_set = SET_K1990;
					nxt.phase      = PH_START;
				end else begin
					res = fail_res;
				end
			end
			default: begin
				res = fail_res;
			end
		endcase
	end

endmodule

FILE: rtl/iso2022jp_escape_decoder_unit.sv
// ISO-2022-JP escape decoder: input word register, decode step, result register.
// Depends on i2jdec_pkg and i2jdec_step.
//
// Usage:
//   Input channel: in_valid / in_stall with stream_byte, one raw byte per word.
//   Output channel: out_valid / out_stall with status, char_set and char_code.
//   A word moves when its valid is high and its stall is low.
//   Configuration: cfg_wen with cfg_wdata writes drop_carriage_return; write it
//   only while no word is in flight.
// Timing:
//   One byte is accepted every cycle while in_stall is low. The decode step works on
//   the byte held in the input register, and its result word is loaded into the
//   result register, from which it can be taken.
//   Escape bytes, kanji lead bytes and dropped carriage returns yield no result word.
// Reset:
//   arst_n clears the pipeline valids, the escape phase (start), the active
//   set (ascii), the held lead byte and the carriage return drop flag.
// Stall:
//   While out_stall holds a result, the input register keeps its byte and
//   in_stall rises once it is full; no word is lost or repeated.
module iso2022jp_escape_decoder_unit
	import i2jdec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [2:0]  char_set,
	output logic [15:0] char_code
);

	logic        drop_cr_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        out_valid_q;
	logic        status_q;
	char_set_t   char_set_q;
	logic [15:0] char_code_q;
	logic        out_load;
	logic        advance;
	logic        in_accept;

	assign out_load  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_load;
	assign in_stall  = valid_s1 && !out_load;
	assign in_accept = in_valid && !in_stall;

	i2jdec_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.drop_cr (drop_cr_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_cr_q <= 1'b0;
		end else if (cfg_wen) begin
			drop_cr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= stream_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, active_set: SET_ASCII, lead_byte: 8'h00,
				lead_pending: 1'b0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status_q    <= res.status;
			char_set_q  <= res.char_set;
			char_code_q <= res.char_code;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign char_set  = char_set_q;
	assign char_code = char_code_q;

endmodule

FILE: sim/iso2022jp_decode_checker.sv
`timescale 1ns / 1ps
// Checker for the ISO-2022-JP escape decoder: follows both channels and the
// configuration port, predicts each result word and compares it in order.
// Depends on i2jdec_pkg for the byte constants, set codes and phase codes.
module iso2022jp_decode_checker
	import i2jdec_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  stream_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic        status,
	input  logic [2:0]  char_set,
	input  logic [15:0] char_code,
	output int          mismatch_count,
	output int          pending_words,
	output int          results_checked
);

	typedef struct packed {
		logic        status;
		char_set_t   cset;
		logic [15:0] code;
	} char_word_t;

	// Shadow of the decoder state.
	phase_t     phase;
	char_set_t  cur_set;
	logic [7:0] lead;
	logic       lead_ok;
	logic       drop_cr;

	char_word_t expected_words[$];
	int         err_count;
	int         checked;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		err_count++;
		$display("%0t ns mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
	endtask

	// Advances the shadow state by one byte; returns 1 when a word is due.
	function automatic bit decode_byte(input logic [7:0] b, output char_word_t w);
		w.status = 1'b0;
		w.cset = cur_set;
		w.code = 16'h0000;
		if (phase != PH_START) begin
			// A byte that does not fit leaves the phase as it is.
			case (phase)
			PH_ESC: begin
				if (b == DOLLAR_BYTE) phase = PH_DOLLAR;
				else if (b == AMP_BYTE) phase = PH_AMP;
				else if (b == LPAREN_BYTE) phase = PH_LPAREN;
				else w.status = 1'b1;
			end
			PH_DOLLAR: begin
				if (b == AT_BYTE) begin
					cur_set = SET_K1978;
					phase = PH_START;
				end else if (b == B_BYTE) begin
					cur_set = SET_K1983;
					phase = PH_START;
				end else w.status = 1'b1;
			end
			PH_AMP: begin
				if (b == AT_BYTE) phase = PH_AMP_AT;
				else w.status = 1'b1;
			end
			PH_LPAREN: begin
				if (b == B_BYTE) begin
					cur_set = SET_ASCII;
					phase = PH_START;
				end else if (b == J_BYTE) begin
					cur_set = SET_ROMAN;
					phase = PH_START;
				end else if (b == I_BYTE) begin
					cur_set = SET_KANA;
					phase = PH_START;
				end else w.status = 1'b1;
			end
			PH_AMP_AT: begin
				if (b == ESC_BYTE) phase = PH_ESC2;
				else w.status = 1'b1;
			end
			PH_ESC2: begin
				if (b == DOLLAR_BYTE) phase = PH_DOLLAR2;
				else w.status = 1'b1;
			end
			default: begin
				if (b == B_BYTE) begin
					cur_set = SET_K1990;
					phase = PH_START;
				end else w.status = 1'b1;
			end
			endcase
			return w.status;
		end
		if (b == ESC_BYTE) begin
			lead = 8'h00;
			lead_ok = 1'b0;
			phase = PH_ESC;
			return 1'b0;
		end
		case (cur_set)
		SET_K1978, SET_K1983, SET_K1990: begin
			if (!lead_ok) begin
				lead = b;
				lead_ok = 1'b1;
				return 1'b0;
			end
			w.code = {lead, b};
			lead = 8'h00;
			lead_ok = 1'b0;
			return 1'b1;
		end
		SET_KANA: begin
			if (b > KANA_LOW && b < KANA_HIGH) w.code = {8'h00, b + KANA_OFFSET};
			else w.status = 1'b1;
			return 1'b1;
		end
		default: begin
			if (drop_cr && b == CR_BYTE) return 1'b0;
			w.code = {8'h00, b};
			return 1'b1;
		end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		char_word_t w;
		char_word_t want;
		if (!arst_n) begin
			phase = PH_START;
			cur_set = SET_ASCII;
			lead = 8'h00;
			lead_ok = 1'b0;
			drop_cr = 1'b0;
			expected_words.delete();
			err_count = 0;
			checked = 0;
			mismatch_count <= 0;
			pending_words <= 0;
			results_checked <= 0;
		end else begin
			if (cfg_wen) drop_cr = cfg_wdata;
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					report_mismatch("result word with none expected, code",
						32'(char_code), 0);
				end else begin
					want = expected_words.pop_front();
					checked++;
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (char_set !== want.cset)
						report_mismatch("char_set", 32'(char_set), 32'(want.cset));
					if (char_code !== want.code)
						report_mismatch("char_code", 32'(char_code), 32'(want.code));
				end
			end
			if (in_valid && !in_stall) begin
				if (decode_byte(stream_byte, w)) expected_words.push_back(w);
			end
			mismatch_count <= err_count;
			pending_words <= expected_words.size();
			results_checked <= checked;
		end
	end

endmodule

FILE: sim/iso2022jp_escape_decoder_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for the ISO-2022-JP escape decoder: clock, reset, byte stimulus,
// random stalls and the verdict. Depends on i2jdec_pkg, the decoder and the checker.
module iso2022jp_escape_decoder_unit_tb
	import i2jdec_pkg::*;
();

	localparam int HALF_PERIOD = 10;
	localparam int RESET_CYCLES = 10;
	localparam int LATENCY_WAIT = 4;
	localparam int RANDOM_BYTES = 1050;
	localparam int PHASES = 4;
	localparam int IDLE_PERCENT = 37;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic        cfg_wdata = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  stream_byte = 8'h00;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire         status;
	wire [2:0]   char_set;
	wire [15:0]  char_code;

	int mismatch_count;
	int pending_words;
	int results_checked;

	bit         steady = 1'b0;
	int         bytes_sent = 0;
	int         sequences_sent = 0;
	int         drop_settings = 0;
	logic [7:0] esc_bytes[$];

	always #(HALF_PERIOD) clk = ~clk;

	iso2022jp_escape_decoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.stream_byte (stream_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.char_set    (char_set),
		.char_code   (char_code)
	);

	iso2022jp_decode_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wen         (cfg_wen),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.stream_byte     (stream_byte),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.char_set        (char_set),
		.char_code       (char_code),
		.mismatch_count  (mismatch_count),
		.pending_words   (pending_words),
		.results_checked (results_checked)
	);

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
	end

	task automatic send_byte(input logic [7:0] b);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
	endtask

	function void fill_escape(input char_set_t s);
		esc_bytes.delete();
		esc_bytes.push_back(ESC_BYTE);
		case (s)
		SET_ASCII: begin
			esc_bytes.push_back(LPAREN_BYTE);
			esc_bytes.push_back(B_BYTE);
		end
		SET_ROMAN: begin
			esc_bytes.push_back(LPAREN_BYTE);
			esc_bytes.push_back(J_BYTE);
		end
		SET_KANA: begin
			esc_bytes.push_back(LPAREN_BYTE);
			esc_bytes.push_back(I_BYTE);
		end
		SET_K1978: begin
			esc_bytes.push_back(DOLLAR_BYTE);
			esc_bytes.push_back(AT_BYTE);
		end
		SET_K1983: begin
			esc_bytes.push_back(DOLLAR_BYTE);
			esc_bytes.push_back(B_BYTE);
		end
		default: begin
			esc_bytes.push_back(AMP_BYTE);
			esc_bytes.push_back(AT_BYTE);
			esc_bytes.push_back(ESC_BYTE);
			esc_bytes.push_back(DOLLAR_BYTE);
			esc_bytes.push_back(B_BYTE);
		end
		endcase
	endfunction

	// Sends the escape sequence for a set; with break_at in range a stray byte
	// is slipped in at that position and the sequence then completes.
	task automatic send_escape(input char_set_t s, input int break_at, input logic [7:0] bad);
		int i;
		fill_escape(s);
		sequences_sent++;
		for (i = 0; i < esc_bytes.size(); i++) begin
			if (i == break_at) send_byte(bad);
			send_byte(esc_bytes[i]);
		end
	endtask

	function automatic logic [7:0] content_byte(input char_set_t s);
		int roll;
		roll = $urandom_range(99);
		if (roll >= 80) return 8'($urandom_range(255));
		case (s)
		SET_KANA: return 8'($urandom_range(8'h5F, 8'h21));
		SET_K1978, SET_K1983, SET_K1990: return 8'($urandom_range(8'h7E, 8'h21));
		default: return (roll < 10) ? CR_BYTE : 8'($urandom_range(8'h7E, 8'h20));
		endcase
	endfunction

	task automatic send_content(input char_set_t s, input int count);
		repeat (count) send_byte(content_byte(s));
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (pending_words != 0);
		repeat (LATENCY_WAIT) @(posedge clk);
	endtask

	task automatic write_drop(input logic v);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		drop_settings++;
	endtask

	initial begin
		#(2_000_000);
		$display("tb: failure");
		$finish;
	end

	initial begin : stimulus
		int ph;
		int phase_end;
		int sel;
		char_set_t s;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_drop(1'b0);

		// Directed part with carriage returns kept.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(CR_BYTE);
		send_escape(SET_ROMAN, -1, 8'h00);
		send_byte(8'h5C);
		send_escape(SET_KANA, -1, 8'h00);
		send_byte(8'h21);
		send_byte(8'h5F);
		send_byte(8'h60);
		send_escape(SET_K1978, -1, 8'h00);
		// A zero lead byte pairs like any other; a carriage return is data here.
		send_byte(8'h00);
		send_byte(CR_BYTE);
		// This lead byte is discarded by the escape that follows.
		send_byte(8'h7F);
		send_escape(SET_K1990, 1, ESC_BYTE);
		send_byte(8'h24);
		send_byte(8'h22);
		send_escape(SET_ASCII, 2, 8'h41);
		in_valid <= 1'b0;

		for (ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			write_drop(ph % 2 == 0);
			steady = (ph == 2);
			if (ph == 0) begin
				// Dropped in ascii and roman, an error in kana.
				send_byte(CR_BYTE);
				send_escape(SET_ROMAN, -1, 8'h00);
				send_byte(CR_BYTE);
				send_escape(SET_KANA, -1, 8'h00);
				send_byte(CR_BYTE);
			end
			phase_end = bytes_sent + RANDOM_BYTES / PHASES;
			while (bytes_sent < phase_end) begin
				sel = $urandom_range(99);
				s = char_set_t'(3'($urandom_range(5)));
				if (sel < 60) begin
					send_escape(s, -1, 8'h00);
					send_content(s, $urandom_range(12, 1));
				end else if (sel < 85) begin
					send_escape(s, $urandom_range((s == SET_K1990) ? 5 : 2, 1),
						8'($urandom_range(255)));
					send_content(s, $urandom_range(6, 1));
				end else begin
					repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
				end
			end
			in_valid <= 1'b0;
		end

		wait_idle();
		$display("Sent %0d bytes with %0d escape sequences under %0d register writes.",
			bytes_sent, sequences_sent, drop_settings);
		$display("Checked %0d result words in order, %0d mismatches.",
			results_checked, mismatch_count);
		if (mismatch_count == 0 && pending_words == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/i2jdec_pkg.sv
rtl/i2jdec_step.sv
rtl/iso2022jp_escape_decoder_unit.sv
sim/iso2022jp_decode_checker.sv
sim/iso2022jp_escape_decoder_unit_tb.sv
